// ----- sv/nearest_palette_color_match_unit_defines.svh -----
// assertion macros for the nearest palette colour match unit
// no dependencies; included by the top level
`ifndef NEAREST_PALETTE_COLOR_MATCH_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MATCH_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define NPCM_ASSERT_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("npcm assertion failed");
`define NPCM_ASSERT(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("npcm assertion failed");
`else
`define NPCM_ASSERT_RST(lbl, clk, rst_n, prop)
`define NPCM_ASSERT(lbl, clk, prop)
`endif
`endif

// ----- sv/npcm_pkg.sv -----
// types and constants for the nearest palette colour match unit
// no dependencies; used by npcm_cell and the top level
package npcm_pkg;

	localparam int PAL_ENTRIES = 256;
	localparam int IDX_W = 8;
	localparam int COMP_W = 8;
	localparam int SQ_W = 2 * COMP_W;
	localparam int DIST_W = 18;
	localparam logic [DIST_W-1:0] NO_MATCH_DIST = '1;
	localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(195075);

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef struct packed {
		logic              valid;
		cmd_t              cmd;
		logic [IDX_W-1:0]  entry_index;
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
		logic [IDX_W-1:0]  lead_index;
		logic [DIST_W-1:0] best_dist;
	} item_t;

	function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
		input logic [COMP_W-1:0] b);
		logic [COMP_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

endpackage

// ----- sv/npcm_cell.sv -----
// one palette cell: holds one entry and scores passing queries in two stages
// depends on npcm_pkg
module npcm_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic [npcm_pkg::IDX_W-1:0] cell_index,
	input  npcm_pkg::item_t          item_in,
	output npcm_pkg::item_t          item_out
);
	import npcm_pkg::*;

	logic [COMP_W-1:0] red_q, green_q, blue_q;
	item_t             item_s1;
	logic [SQ_W-1:0]   sq_r_s1, sq_g_s1, sq_b_s1;
	item_t             item_s2;
	logic [DIST_W-1:0] sum_sq;
	logic              hit_wr;
	logic              better;

	assign hit_wr = item_in.valid && (item_in.cmd == CMD_WRITE) &&
		(item_in.entry_index == cell_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else if (adv && hit_wr) begin
			red_q   <= item_in.red;
			green_q <= item_in.green;
			blue_q  <= item_in.blue;
		end
	end

	// stage 1: component squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (adv) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_r_s1 <= sq_diff(red_q, item_in.red);
			sq_g_s1 <= sq_diff(green_q, item_in.green);
			sq_b_s1 <= sq_diff(blue_q, item_in.blue);
		end
	end

	// stage 2: sum and strict compare, lowest index wins ties
	assign sum_sq = DIST_W'(sq_r_s1) + DIST_W'(sq_g_s1) + DIST_W'(sq_b_s1);
	assign better = (item_s1.cmd == CMD_QUERY) && (sum_sq < item_s1.best_dist);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2 <= '0;
		end else if (adv) begin
			item_s2.valid       <= item_s1.valid;
			item_s2.cmd         <= item_s1.cmd;
			item_s2.entry_index <= item_s1.entry_index;
			item_s2.red         <= item_s1.red;
			item_s2.green       <= item_s1.green;
			item_s2.blue        <= item_s1.blue;
			item_s2.lead_index  <= better ? cell_index : item_s1.lead_index;
			item_s2.best_dist   <= better ? sum_sq : item_s1.best_dist;
		end
	end

	assign item_out = item_s2;

endmodule

// ----- sv/nearest_palette_color_match_unit.sv -----
// path: an accepted request passes through the cell stages in index order, then the response register
// throughput: one transaction per cycle; two register stages in each of the
// PAL_ENTRIES palette cells, the whole chain halts while a response is held
// reset: palette entries cleared to zero, chain and response register emptied
// depends on npcm_pkg, npcm_cell and nearest_palette_color_match_unit_defines.svh
`include "nearest_palette_color_match_unit_defines.svh"
module nearest_palette_color_match_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic                        cmd,
	input  logic [npcm_pkg::IDX_W-1:0]  entry_index,
	input  logic [npcm_pkg::COMP_W-1:0] red,
	input  logic [npcm_pkg::COMP_W-1:0] green,
	input  logic [npcm_pkg::COMP_W-1:0] blue,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [npcm_pkg::IDX_W-1:0]  match_index,
	output logic [npcm_pkg::DIST_W-1:0] match_distance
);
	import npcm_pkg::*;

	logic              adv;
	item_t             chain [PAL_ENTRIES+1];
	item_t             tail;
	logic              rsp_valid_q;
	logic [IDX_W-1:0]  match_index_q;
	logic [DIST_W-1:0] match_distance_q;

	assign adv = !rsp_valid_q || rsp_ready;
	assign req_ready = adv;

	always_comb begin
		chain[0].valid       = req_valid && adv;
		chain[0].cmd         = cmd_t'(cmd);
		chain[0].entry_index = entry_index;
		chain[0].red         = red;
		chain[0].green       = green;
		chain[0].blue        = blue;
		chain[0].lead_index  = '0;
		chain[0].best_dist   = NO_MATCH_DIST;
	end

	for (genvar i = 0; i < PAL_ENTRIES; i++) begin : g_cell
		npcm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.cell_index (IDX_W'(i)),
			.item_in    (chain[i]),
			.item_out   (chain[i+1])
		);
	end

	assign tail = chain[PAL_ENTRIES];

	// writes leave the chain here, only queries make a response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= tail.valid && (tail.cmd == CMD_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			match_index_q    <= tail.lead_index;
			match_distance_q <= tail.best_dist;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign match_index    = match_index_q;
	assign match_distance = match_distance_q;

	`NPCM_ASSERT_RST(a_hold_freezes_chain, clk, arst_n, (rsp_valid && !rsp_ready) |-> !req_ready)
	`NPCM_ASSERT(a_dist_in_range, clk, rsp_valid |-> (match_distance <= MAX_DIST))
	`NPCM_ASSERT(a_index_in_range, clk, rsp_valid |-> ({1'b0, match_index} < (IDX_W+1)'(PAL_ENTRIES)))

endmodule
